[design/msjd_pkg.sv]
package msjd_pkg;

   localparam int DEF_NUM_SERVERS = 8;
   localparam int DEF_WAIT_DEPTH  = 1024;
   localparam int DEF_TIME_BITS   = 32;

   typedef enum logic [1:0] {
      OP_ARRIVE   = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_OBSERVE  = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  server_id;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic        dispatched;
      logic [2:0]  dispatch_server;
      logic        queued;
      logic        dropped;
      logic        bad_completion;
      logic [10:0] waiting_count;
      logic [3:0]  busy_count;
      logic [31:0] served_total;
      logic [47:0] delay_total;
      logic [31:0] observation_total;
      logic [47:0] occupancy_total;
      logic [31:0] empty_total;
   } rsp_type;

   // one update of the running statistics
   typedef struct packed {
      logic        served;
      logic        observed;
      logic        empty;
      logic [47:0] delay;
      logic [47:0] jobs;
   } stats_upd_type;

   typedef struct packed {
      logic [31:0] served;
      logic [47:0] delay;
      logic [31:0] observe;
      logic [47:0] occupancy;
      logic [31:0] empty;
   } stats_type;

   typedef struct packed {
      logic pop;
      logic push;
   } idle_cmd_type;

endpackage

[design/multi_server_job_dispatcher.sv]
// Channel   Ports                          Direction  Payload
// request   req_valid/req_ready/req_data   in         msjd_pkg::req_type
// response  rsp_valid/rsp_ready/rsp_data   out        msjd_pkg::rsp_type
//
// Each request is handled in order: the accept issues reads of the stamp
// memory and the waiting-queue memory, and the write-back that follows
// loads the response. Both of those memories have a registered read.
// Synchronous reset empties the waiting queue and marks every server idle.
// A held response stalls only the write-back; the next request is taken
// once the current one has written back.
module multi_server_job_dispatcher #(
   parameter int NUM_SERVERS = msjd_pkg::DEF_NUM_SERVERS,
   parameter int WAIT_DEPTH  = msjd_pkg::DEF_WAIT_DEPTH,
   parameter int TIME_BITS   = msjd_pkg::DEF_TIME_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msjd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msjd_pkg::rsp_type rsp_data
);

   localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int CNT_W = $clog2(NUM_SERVERS + 1);
   localparam int WH_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WC_W  = $clog2(WAIT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   msjd_pkg::req_type      req_ff;
   logic [WH_W-1:0]        wait_head_ff, wait_head_in;
   logic [WC_W-1:0]        wait_count_ff, wait_count_in;
   logic                   rsp_valid_ff;
   logic                   disp_ff, disp_in;
   logic [2:0]             dsrv_ff, dsrv_in;
   logic                   queued_ff, queued_in;
   logic                   dropped_ff, dropped_in;
   logic                   bad_ff, bad_in;

   logic                   accept;
   logic                   commit;
   logic [TIME_BITS-1:0]   start_rd;
   logic [TIME_BITS-1:0]   wait_rd;
   logic                   start_we;
   logic [SRV_W-1:0]       start_waddr;
   logic [TIME_BITS-1:0]   start_wdata;
   logic                   wait_we;
   logic [TIME_BITS-1:0]   now_t;
   logic [TIME_BITS-1:0]   delay_t;
   logic [WH_W:0]          tail_sum;
   logic [WH_W:0]          tail_wrap;
   logic [WH_W-1:0]        head_next;
   logic                   in_range;
   logic [SRV_W-1:0]       sid_idx;
   logic                   busy_hit;
   logic [CNT_W-1:0]       busy_now;
   logic [47:0]            jobs;

   msjd_pkg::idle_cmd_type  idle_cmd;
   logic [SRV_W-1:0]        head_id;
   logic [CNT_W-1:0]        idle_count;
   logic [NUM_SERVERS-1:0]  busy;
   msjd_pkg::stats_upd_type upd;
   msjd_pkg::stats_type     totals;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   msjd_ram #(
      .DEPTH (NUM_SERVERS),
      .WIDTH (TIME_BITS)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (start_waddr),
      .wr_data (start_wdata),
      .rd_en   (accept),
      .rd_addr (SRV_W'(req_data.server_id)),
      .rd_data (start_rd)
   );

   msjd_ram #(
      .DEPTH (WAIT_DEPTH),
      .WIDTH (TIME_BITS)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wait_we),
      .wr_addr (tail_wrap[WH_W-1:0]),
      .wr_data (now_t),
      .rd_en   (accept),
      .rd_addr (wait_head_ff),
      .rd_data (wait_rd)
   );

   msjd_idle #(
      .NUM_SERVERS (NUM_SERVERS)
   ) u_idle (
      .clock      (clock),
      .reset      (reset),
      .cmd        (idle_cmd),
      .push_id    (sid_idx),
      .head_id    (head_id),
      .idle_count (idle_count),
      .busy       (busy)
   );

   msjd_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .upd    (upd),
      .totals (totals)
   );

   always_comb begin
      now_t     = TIME_BITS'(req_ff.now);
      delay_t   = now_t - start_rd;
      tail_sum  = {1'b0, wait_head_ff} + (WH_W+1)'(wait_count_ff);
      tail_wrap = (tail_sum >= (WH_W+1)'(WAIT_DEPTH)) ?
                  tail_sum - (WH_W+1)'(WAIT_DEPTH) : tail_sum;
      head_next = ({1'b0, wait_head_ff} == (WH_W+1)'(WAIT_DEPTH - 1)) ?
                  '0 : wait_head_ff + 1'b1;
      in_range  = 7'(req_ff.server_id) < 7'(NUM_SERVERS);
      sid_idx   = SRV_W'(req_ff.server_id);
      busy_hit  = in_range && busy[sid_idx];
      busy_now  = CNT_W'(NUM_SERVERS) - idle_count;
      jobs      = 48'(wait_count_ff) + 48'(busy_now);

      state_in      = state_ff;
      wait_head_in  = wait_head_ff;
      wait_count_in = wait_count_ff;
      disp_in       = 1'b0;
      dsrv_in       = '0;
      queued_in     = 1'b0;
      dropped_in    = 1'b0;
      bad_in        = 1'b0;
      start_we      = 1'b0;
      start_waddr   = head_id;
      start_wdata   = now_t;
      wait_we       = 1'b0;
      idle_cmd      = '0;
      upd           = '0;

      if (accept) begin
         state_in = ST_EXEC;
      end

      if (commit) begin
         state_in = ST_IDLE;
         case (req_ff.op)
            msjd_pkg::OP_ARRIVE: begin
               if (idle_count != '0) begin
                  idle_cmd.pop = 1'b1;
                  start_we     = 1'b1;
                  disp_in      = 1'b1;
                  dsrv_in      = 3'(head_id);
               end else if (wait_count_ff != WC_W'(WAIT_DEPTH)) begin
                  wait_we       = 1'b1;
                  wait_count_in = wait_count_ff + 1'b1;
                  queued_in     = 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
            msjd_pkg::OP_COMPLETE: begin
               if (!busy_hit) begin
                  bad_in = 1'b1;
               end else begin
                  upd.served = 1'b1;
                  upd.delay  = 48'(delay_t);
                  if (wait_count_ff != '0) begin
                     // restart the server with the oldest waiting job
                     start_we      = 1'b1;
                     start_waddr   = sid_idx;
                     start_wdata   = wait_rd;
                     wait_head_in  = head_next;
                     wait_count_in = wait_count_ff - 1'b1;
                     disp_in       = 1'b1;
                     dsrv_in       = req_ff.server_id;
                  end else begin
                     idle_cmd.push = 1'b1;
                  end
               end
            end
            msjd_pkg::OP_OBSERVE: begin
               upd.observed = 1'b1;
               upd.jobs     = jobs;
               upd.empty    = (jobs == '0);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wait_head_ff  <= '0;
         wait_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wait_head_ff  <= wait_head_in;
         wait_count_ff <= wait_count_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         disp_ff    <= disp_in;
         dsrv_ff    <= dsrv_in;
         queued_ff  <= queued_in;
         dropped_ff <= dropped_in;
         bad_ff     <= bad_in;
      end
   end

   // counts and sums change only on write-back, so they hold with the response
   always_comb begin
      rsp_data.dispatched        = disp_ff;
      rsp_data.dispatch_server   = dsrv_ff;
      rsp_data.queued            = queued_ff;
      rsp_data.dropped           = dropped_ff;
      rsp_data.bad_completion    = bad_ff;
      rsp_data.waiting_count     = 11'(wait_count_ff);
      rsp_data.busy_count        = 4'(busy_now);
      rsp_data.served_total      = totals.served;
      rsp_data.delay_total       = totals.delay;
      rsp_data.observation_total = totals.observe;
      rsp_data.occupancy_total   = totals.occupancy;
      rsp_data.empty_total       = totals.empty;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/msjd_ram.sv]
module msjd_ram #(
   parameter int DEPTH = msjd_pkg::DEF_WAIT_DEPTH,
   parameter int WIDTH = msjd_pkg::DEF_TIME_BITS,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/msjd_idle.sv]
module msjd_idle #(
   parameter int NUM_SERVERS = msjd_pkg::DEF_NUM_SERVERS,
   localparam int SRV_W      = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1,
   localparam int CNT_W      = $clog2(NUM_SERVERS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  msjd_pkg::idle_cmd_type cmd,
   input  logic [SRV_W-1:0]       push_id,
   output logic [SRV_W-1:0]       head_id,
   output logic [CNT_W-1:0]       idle_count,
   output logic [NUM_SERVERS-1:0] busy
);

   logic [SRV_W-1:0]       fifo_ff [NUM_SERVERS];
   logic [SRV_W-1:0]       head_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [NUM_SERVERS-1:0] busy_ff;
   logic [SRV_W:0]         tail_sum;
   logic [SRV_W:0]         tail_wrap;
   logic [SRV_W-1:0]       tail_idx;
   logic [SRV_W-1:0]       head_in;

   always_comb begin
      tail_sum  = {1'b0, head_ff} + (SRV_W+1)'(count_ff);
      tail_wrap = (tail_sum >= (SRV_W+1)'(NUM_SERVERS)) ?
                  tail_sum - (SRV_W+1)'(NUM_SERVERS) : tail_sum;
      tail_idx  = tail_wrap[SRV_W-1:0];
      head_in   = (head_ff == SRV_W'(NUM_SERVERS - 1)) ? '0 : head_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SERVERS; i++) begin
            fifo_ff[i] <= SRV_W'(i);
         end
         head_ff  <= '0;
         count_ff <= CNT_W'(NUM_SERVERS);
         busy_ff  <= '0;
      end else if (cmd.pop) begin
         head_ff                   <= head_in;
         count_ff                  <= count_ff - 1'b1;
         busy_ff[fifo_ff[head_ff]] <= 1'b1;
      end else if (cmd.push) begin
         fifo_ff[tail_idx] <= push_id;
         count_ff          <= count_ff + 1'b1;
         busy_ff[push_id]  <= 1'b0;
      end
   end

   assign head_id    = fifo_ff[head_ff];
   assign idle_count = count_ff;
   assign busy       = busy_ff;

endmodule

[design/msjd_stats.sv]
module msjd_stats (
   input  logic                    clock,
   input  logic                    reset,
   input  msjd_pkg::stats_upd_type upd,
   output msjd_pkg::stats_type     totals
);

   msjd_pkg::stats_type sums_ff;
   msjd_pkg::stats_type sums_in;
   logic [48:0]         delay_sum;
   logic [48:0]         occ_sum;

   always_comb begin
      delay_sum = {1'b0, sums_ff.delay} + {1'b0, upd.delay};
      occ_sum   = {1'b0, sums_ff.occupancy} + {1'b0, upd.jobs};
      sums_in   = sums_ff;
      if (upd.served) begin
         if (sums_ff.served != '1) begin
            sums_in.served = sums_ff.served + 32'd1;
         end
         sums_in.delay = delay_sum[48] ? '1 : delay_sum[47:0];
      end
      if (upd.observed) begin
         if (sums_ff.observe != '1) begin
            sums_in.observe = sums_ff.observe + 32'd1;
         end
         sums_in.occupancy = occ_sum[48] ? '1 : occ_sum[47:0];
         if (upd.empty && sums_ff.empty != '1) begin
            sums_in.empty = sums_ff.empty + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

   assign totals = sums_ff;

endmodule

[design/msjd_checker.sv]
module msjd_checker #(
   parameter int NUM_SERVERS = msjd_pkg::DEF_NUM_SERVERS
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input msjd_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input msjd_pkg::rsp_type rsp_data
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request in flight: the port closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !$isunknown(req_data.op) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // served, delay and occupancy sums never go down
   a_sums_grow: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> rsp_data.served_total >= $past(rsp_data.served_total) &&
               rsp_data.delay_total >= $past(rsp_data.delay_total) &&
               rsp_data.occupancy_total >= $past(rsp_data.occupancy_total))
      else $error("running sum decreased");

   // a job only waits or drops when every server is busy
   a_wait_all_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.queued || rsp_data.dropped) |->
         rsp_data.busy_count == 4'(NUM_SERVERS))
      else $error("request queued while a server was idle");

endmodule

bind multi_server_job_dispatcher msjd_checker #(
   .NUM_SERVERS (NUM_SERVERS)
) u_msjd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/multi_server_job_dispatcher_test.sv]
module multi_server_job_dispatcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSRV = msjd_pkg::DEF_NUM_SERVERS;
   localparam int WDEPTH = msjd_pkg::DEF_WAIT_DEPTH;
   localparam msjd_pkg::op_type OP_SPARE = msjd_pkg::op_type'(2'd3);
   localparam longint unsigned CAP32 = 64'hFFFF_FFFF;
   localparam longint unsigned CAP48 = 64'hFFFF_FFFF_FFFF;
   localparam int FLOOD_DEPTH = 32;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      msjd_pkg::req_type req;
      logic              fixed;
      msjd_pkg::rsp_type rsp;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   msjd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   msjd_pkg::rsp_type rsp_data;

   // predicted dispatcher state
   bit [31:0]       stamp[NSRV];
   bit              busy[NSRV];
   bit [2:0]        idle_ring[NSRV];
   int              idle_n;
   int              idle_rd;
   bit [31:0]       wait_ring[WDEPTH];
   int              waiting_n;
   int              wait_rd;
   longint unsigned served_acc;
   longint unsigned delay_acc;
   longint unsigned observe_acc;
   longint unsigned occupancy_acc;
   longint unsigned empty_acc;

   msjd_pkg::rsp_type promised[$];
   plan_row_type      script[$];

   int        send_gap_pct = 0;
   int        recv_stall_pct = 0;
   int        recv_hold = 0;
   int        mismatches = 0;
   bit [31:0] ticks;
   int        n_requests = 0;
   int        n_dispatch = 0;
   int        n_queued = 0;
   int        n_dropped = 0;
   int        n_bad = 0;
   int        peak_waiting = 0;

   multi_server_job_dispatcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned x,
                                               longint unsigned cap);
      if (x >= cap || acc > cap - x)
         return cap;
      return acc + x;
   endfunction

   function automatic void dispatcher_reset();
      for (int i = 0; i < NSRV; i++) begin
         stamp[i] = '0;
         busy[i] = 1'b0;
         idle_ring[i] = 3'(i);
      end
      idle_n = NSRV;
      idle_rd = 0;
      waiting_n = 0;
      wait_rd = 0;
      served_acc = 0;
      delay_acc = 0;
      observe_acc = 0;
      occupancy_acc = 0;
      empty_acc = 0;
   endfunction

   // advance the predicted state by one request and return its response
   function automatic msjd_pkg::rsp_type predict_dispatch(msjd_pkg::req_type r);
      msjd_pkg::rsp_type o;
      int                srv;
      int                jobs;
      bit [31:0]         delay;
      o = '0;
      case (r.op)
         msjd_pkg::OP_ARRIVE: begin
            if (idle_n > 0) begin
               srv = idle_ring[idle_rd];
               idle_rd = (idle_rd + 1) % NSRV;
               idle_n--;
               stamp[srv] = r.now;
               busy[srv] = 1'b1;
               o.dispatched = 1'b1;
               o.dispatch_server = 3'(srv);
            end else if (waiting_n < WDEPTH) begin
               wait_ring[(wait_rd + waiting_n) % WDEPTH] = r.now;
               waiting_n++;
               o.queued = 1'b1;
            end else begin
               o.dropped = 1'b1;
            end
         end
         msjd_pkg::OP_COMPLETE: begin
            srv = r.server_id;
            if (srv >= NSRV || !busy[srv]) begin
               o.bad_completion = 1'b1;
            end else begin
               delay = r.now - stamp[srv];
               served_acc = sat_add(served_acc, 1, CAP32);
               delay_acc = sat_add(delay_acc, delay, CAP48);
               if (waiting_n > 0) begin
                  stamp[srv] = wait_ring[wait_rd];
                  wait_rd = (wait_rd + 1) % WDEPTH;
                  waiting_n--;
                  o.dispatched = 1'b1;
                  o.dispatch_server = r.server_id;
               end else begin
                  busy[srv] = 1'b0;
                  stamp[srv] = '0;
                  idle_ring[(idle_rd + idle_n) % NSRV] = r.server_id;
                  idle_n++;
               end
            end
         end
         msjd_pkg::OP_OBSERVE: begin
            jobs = waiting_n + NSRV - idle_n;
            observe_acc = sat_add(observe_acc, 1, CAP32);
            occupancy_acc = sat_add(occupancy_acc, jobs, CAP48);
            if (jobs == 0)
               empty_acc = sat_add(empty_acc, 1, CAP32);
         end
         default: ;
      endcase
      o.waiting_count = 11'(waiting_n);
      o.busy_count = 4'(NSRV - idle_n);
      o.served_total = served_acc[31:0];
      o.delay_total = delay_acc[47:0];
      o.observation_total = observe_acc[31:0];
      o.occupancy_total = occupancy_acc[47:0];
      o.empty_total = empty_acc[31:0];
      return o;
   endfunction

   function automatic msjd_pkg::rsp_type fixed_outcome(bit disp, int srv, bit q, bit drop,
                                                       bit bad, int waiting, int nbusy,
                                                       longint unsigned served,
                                                       longint unsigned delay,
                                                       longint unsigned observed,
                                                       longint unsigned occupancy,
                                                       longint unsigned empties);
      msjd_pkg::rsp_type o;
      o.dispatched = disp;
      o.dispatch_server = 3'(srv);
      o.queued = q;
      o.dropped = drop;
      o.bad_completion = bad;
      o.waiting_count = 11'(waiting);
      o.busy_count = 4'(nbusy);
      o.served_total = served[31:0];
      o.delay_total = delay[47:0];
      o.observation_total = observed[31:0];
      o.occupancy_total = occupancy[47:0];
      o.empty_total = empties[31:0];
      return o;
   endfunction

   function automatic msjd_pkg::req_type make_req(msjd_pkg::op_type op, int sid,
                                                  bit [31:0] now);
      msjd_pkg::req_type r;
      r.op = op;
      r.server_id = 3'(sid);
      r.now = now;
      return r;
   endfunction

   function automatic int pick_busy();
      int first;
      first = $urandom_range(NSRV - 1);
      for (int i = 0; i < NSRV; i++)
         if (busy[(first + i) % NSRV])
            return (first + i) % NSRV;
      return -1;
   endfunction

   function automatic bit [31:0] next_time();
      ticks += $urandom_range(0, 400);
      return ($urandom_range(9) == 0) ? $urandom() : ticks;
   endfunction

   // mostly arrivals and completions of busy servers, some noise
   function automatic msjd_pkg::req_type random_request();
      int        pick;
      int        srv;
      bit [31:0] now;
      now = next_time();
      pick = $urandom_range(99);
      srv = pick_busy();
      if (pick < 38 || (pick < 75 && srv < 0))
         return make_req(msjd_pkg::OP_ARRIVE, $urandom_range(7), now);
      if (pick < 75)
         return make_req(msjd_pkg::OP_COMPLETE, srv, now);
      if (pick < 88)
         return make_req(msjd_pkg::OP_OBSERVE, $urandom_range(7), now);
      if (pick < 95)
         return make_req(msjd_pkg::OP_COMPLETE, $urandom_range(7), now);
      return make_req(OP_SPARE, $urandom_range(7), now);
   endfunction

   task automatic send_request(msjd_pkg::req_type r, bit fixed, msjd_pkg::rsp_type fixed_rsp);
      msjd_pkg::rsp_type model_rsp;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      model_rsp = predict_dispatch(r);
      promised.insert(promised.size(), fixed ? fixed_rsp : model_rsp);
      n_requests++;
      n_dispatch += model_rsp.dispatched;
      n_queued += model_rsp.queued;
      n_dropped += model_rsp.dropped;
      n_bad += model_rsp.bad_completion;
      if (waiting_n > peak_waiting)
         peak_waiting = waiting_n;
   endtask

   task automatic issue(msjd_pkg::req_type r);
      send_request(r, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (promised.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_row(msjd_pkg::op_type op, int sid, bit [31:0] now, bit fixed,
                          msjd_pkg::rsp_type rsp);
      plan_row_type row;
      row.req = make_req(op, sid, now);
      row.fixed = fixed;
      row.rsp = rsp;
      script.insert(script.size(), row);
   endtask

   task automatic run_directed();
      add_row(msjd_pkg::OP_OBSERVE, 0, 32'h0, 1,
              fixed_outcome(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      add_row(msjd_pkg::OP_COMPLETE, 0, 32'h1234_5678, 1,
              fixed_outcome(0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1));
      add_row(OP_SPARE, 7, 32'hFFFF_FFFF, 1,
              fixed_outcome(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      add_row(msjd_pkg::OP_ARRIVE, 0, 32'hFFFF_FFFF, 1,
              fixed_outcome(1, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1));
      // delay wraps past zero
      add_row(msjd_pkg::OP_COMPLETE, 0, 32'h0, 1,
              fixed_outcome(0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 1));
      add_row(msjd_pkg::OP_COMPLETE, 7, 32'h0, 1,
              fixed_outcome(0, 0, 0, 0, 1, 0, 0, 1, 1, 1, 0, 1));
      for (int i = 0; i < NSRV; i++)
         add_row(msjd_pkg::OP_ARRIVE, 7 - i, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA, 0, '0);
      add_row(msjd_pkg::OP_ARRIVE, 5, 32'hAAAA_AAAA, 0, '0);
      add_row(msjd_pkg::OP_OBSERVE, 2, 32'h5555_5555, 0, '0);
      add_row(msjd_pkg::OP_COMPLETE, 7, 32'hFFFF_FFFF, 0, '0);
      for (int i = 0; i < NSRV; i++)
         add_row(msjd_pkg::OP_COMPLETE, i, 32'h8000_0000, 0, '0);
      add_row(msjd_pkg::OP_OBSERVE, 0, 32'h8000_0001, 0, '0);
      foreach (script[i])
         send_request(script[i].req, script[i].fixed, script[i].rsp);
   endtask

   task automatic run_random(int count, bit with_hold);
      for (int i = 0; i < count; i++) begin
         // hold the response side while requests keep coming
         if (with_hold && i == count / 3)
            recv_hold = HOLD_CYCLES;
         issue(random_request());
      end
   endtask

   task automatic flood_waiting();
      while (waiting_n < FLOOD_DEPTH) begin
         issue(make_req(msjd_pkg::OP_ARRIVE, $urandom_range(7), next_time()));
         if ($urandom_range(63) == 0)
            issue(make_req(msjd_pkg::OP_OBSERVE, $urandom_range(7), next_time()));
      end
      repeat (4) issue(make_req(msjd_pkg::OP_ARRIVE, $urandom_range(7), next_time()));
      issue(make_req(msjd_pkg::OP_OBSERVE, 0, next_time()));
      issue(make_req(msjd_pkg::OP_ARRIVE, 7, next_time()));
   endtask

   task automatic drain_servers();
      while (pick_busy() >= 0)
         issue(make_req(msjd_pkg::OP_COMPLETE, pick_busy(), next_time()));
   endtask

   task automatic compare_field(string name, logic [47:0] got, logic [47:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
      end
   endtask

   task automatic check_response(msjd_pkg::rsp_type got);
      msjd_pkg::rsp_type want;
      if (promised.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response %0h with no request pending", $realtime, got);
      end else begin
         want = promised.pop_front();
         compare_field("dispatched", got.dispatched, want.dispatched);
         compare_field("dispatch_server", got.dispatch_server, want.dispatch_server);
         compare_field("queued", got.queued, want.queued);
         compare_field("dropped", got.dropped, want.dropped);
         compare_field("bad_completion", got.bad_completion, want.bad_completion);
         compare_field("waiting_count", got.waiting_count, want.waiting_count);
         compare_field("busy_count", got.busy_count, want.busy_count);
         compare_field("served_total", got.served_total, want.served_total);
         compare_field("delay_total", got.delay_total, want.delay_total);
         compare_field("observation_total", got.observation_total, want.observation_total);
         compare_field("occupancy_total", got.occupancy_total, want.occupancy_total);
         compare_field("empty_total", got.empty_total, want.empty_total);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold > 0) begin
         rsp_ready <= 1'b0;
         recv_hold = recv_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_response(rsp_data);
   end

   initial begin
      dispatcher_reset();
      ticks = $urandom();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct = 21;
      recv_stall_pct = 54;
      run_directed();
      wait_drained();
      run_random(150, 1);
      flood_waiting();
      drain_servers();
      wait_drained();

      send_gap_pct = 54;
      recv_stall_pct = 21;
      run_random(140, 0);
      drain_servers();
      wait_drained();

      send_gap_pct = 0;
      recv_stall_pct = 0;
      run_random(40, 0);
      drain_servers();
      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d requests: %0d dispatches, %0d queued, %0d dropped, %0d bad",
               n_requests, n_dispatch, n_queued, n_dropped, n_bad);
      $display("deepest wait queue %0d, %0d jobs served, %0d observations",
               peak_waiting, served_acc, observe_acc);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
design/msjd_pkg.sv
design/msjd_ram.sv
design/msjd_idle.sv
design/msjd_stats.sv
design/multi_server_job_dispatcher.sv
design/msjd_checker.sv
tb/multi_server_job_dispatcher_test.sv
